[rtl/texture_mip_chain_size_layout_core_defines.svh]
// Assertion macros shared by the mip chain layout RTL.
`ifndef TEXTURE_MIP_CHAIN_SIZE_LAYOUT_CORE_DEFINES_SVH
`define TEXTURE_MIP_CHAIN_SIZE_LAYOUT_CORE_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define TMCL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMCL_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tmcl_pkg.sv]
// Types, constants and helper functions for the mip chain layout block.
package tmcl_pkg;

   localparam int MAX_LEVELS      = 16;
   localparam int TILE_TABLE_ROWS = 27;
   localparam int LVL_W           = 4;
   localparam int SZ_W            = 58;
   localparam int MUL_A_W         = 48;
   localparam int MUL_B_W         = 16;
   localparam int MUL_P_W         = MUL_A_W + MUL_B_W;

   localparam logic [SZ_W-1:0] CAP58 = '1;

   localparam logic [1:0] KIND_LINEAR   = 2'd0;
   localparam logic [1:0] KIND_MICRO    = 2'd1;
   localparam logic [1:0] KIND_MACRO    = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   typedef struct packed {
      logic [14:0] pitch_elements;
      logic [14:0] height_rows;
      logic [11:0] depth_slices;
      logic [7:0]  bits_per_element;
      logic        block_compressed;
      logic        pow2_pad;
      logic [1:0]  tiling_kind;
      logic [4:0]  tile_table_index;
      logic [4:0]  level_count;
      logic [11:0] layer_count;
      logic [1:0]  samples_log2;
      logic        is_cube;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]      level_index;
      logic [SZ_W-1:0] level_offset;
      logic [SZ_W-1:0] level_bytes;
      logic [SZ_W-1:0] total_bytes;
      logic            last_level;
      logic            error;
   } rsp_payload_type;

   typedef struct packed {
      logic [8:0] ew;
      logic [8:0] eh;
   } extent_type;

   typedef struct packed {
      logic       err;
      extent_type ext;
   } check_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_ERR, ST_SETUP, ST_ALIGN,
      ST_LIN_MUL, ST_LIN_CHK,
      ST_MIC_MUL, ST_MIC_MULB, ST_MIC_CHK,
      ST_MAC_MUL, ST_BYTES_MUL, ST_BYTES_CHK,
      ST_DEP_MUL, ST_DEP_CHK, ST_ACC,
      ST_TOT_LO, ST_TOT_HI, ST_TOT_SUM, ST_EMIT
   } state_type;

   // macro tile extents, row by column (log2 of element bits minus 3)
   function automatic extent_type tile_extent(input logic [4:0] row, input logic [1:0] col);
      extent_type e25612, e25625, e12812, e12864, e6464, ezero, r;
      begin
         e25612 = '{ew: 9'd256, eh: 9'd128};
         e25625 = '{ew: 9'd256, eh: 9'd256};
         e12812 = '{ew: 9'd128, eh: 9'd128};
         e12864 = '{ew: 9'd128, eh: 9'd64};
         e6464  = '{ew: 9'd64,  eh: 9'd64};
         ezero  = '{ew: 9'd0,   eh: 9'd0};
         case (row)
            5'd0: r = e25612;
            5'd1: r = (col == 2'd0) ? e25612 : e12812;
            5'd2, 5'd3, 5'd4, 5'd10, 5'd14, 5'd15: begin
               case (col)
                  2'd0: r = e25612;
                  2'd1: r = e12812;
                  default: r = e12864;
               endcase
            end
            5'd6: begin
               case (col)
                  2'd0: r = e25625;
                  2'd1: r = e25612;
                  default: r = e12812;
               endcase
            end
            5'd7, 5'd11, 5'd12, 5'd16, 5'd17, 5'd18: begin
               case (col)
                  2'd0: r = e25625;
                  2'd1: r = e25612;
                  2'd2: r = e12812;
                  default: r = e12864;
               endcase
            end
            5'd20, 5'd21: r = (col[1]) ? e6464 : e12864;
            5'd22, 5'd23, 5'd24: begin
               case (col)
                  2'd0: r = e12812;
                  2'd1: r = e12864;
                  default: r = e6464;
               endcase
            end
            5'd25, 5'd26: r = (col == 2'd0) ? e12864 : e6464;
            default: r = ezero;
         endcase
         return r;
      end
   endfunction

   // smallest power of two not below v, v at least 1 and at most 2^15
   function automatic logic [15:0] pow2_up(input logic [15:0] v);
      logic [15:0] x;
      begin
         x = v - 16'd1;
         x = x | (x >> 1);
         x = x | (x >> 2);
         x = x | (x >> 4);
         x = x | (x >> 8);
         return x + 16'd1;
      end
   endfunction

   // linear pitch alignment in elements: max(8, 64 / bytes)
   function automatic logic [6:0] lin_align(input logic [9:0] bytes);
      logic [6:0] a;
      begin
         case (bytes)
            10'd1:   a = 7'd64;
            10'd2:   a = 7'd32;
            10'd3:   a = 7'd21;
            10'd4:   a = 7'd16;
            10'd5:   a = 7'd12;
            10'd6:   a = 7'd10;
            10'd7:   a = 7'd9;
            default: a = 7'd8;
         endcase
         return a;
      end
   endfunction

endpackage

[rtl/tmcl_if.sv]
// Valid/ready channel interfaces for descriptor and level result beats.
interface tmcl_req_if import tmcl_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tmcl_rsp_if import tmcl_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/texture_mip_chain_size_layout_core.sv]
// Top level: sequencer and datapath of the mip chain size and layout unit.
//
//  channel  dir  beat                         ports
//  req      in   one texture descriptor       req_chan.valid/ready/payload
//  rsp      out  one level (offset, size)     rsp_chan.valid/ready/payload
//
// One descriptor gives 1..16 level beats after the check state; an error gives one beat.
// Each level steps through states that share the one multiplier; a linear padding step
// runs ST_LIN_MUL and ST_LIN_CHK, a micro one ST_MIC_MUL, ST_MIC_MULB and ST_MIC_CHK (at most
// 256 steps each); the last level adds ST_TOT_LO, ST_TOT_HI and ST_TOT_SUM for the layer product.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled rsp holds the sequencer in its emit or error state; req is taken only idle.
`include "texture_mip_chain_size_layout_core_defines.svh"

module texture_mip_chain_size_layout_core import tmcl_pkg::*; (
   input logic         clock,
   input logic         reset,
   tmcl_req_if.sink    req_chan,
   tmcl_rsp_if.source  rsp_chan
);

   state_type state_ff, state_in;

   req_payload_type    desc_ff, desc_in;
   extent_type         ext_ff, ext_in;
   logic [3:0]         lvl_ff, lvl_in, lvl_last_ff, lvl_last_in;
   logic [15:0]        w_ff, w_in, h_ff, h_in;
   logic [12:0]        d_ff, d_in;
   logic [11:0]        b_ff, b_in;
   logic [6:0]         a_ff, a_in;
   logic [16:0]        p_ff, p_in;
   logic [8:0]         iter_ff, iter_in;
   logic [47:0]        s_ff, s_in, sz_ff, sz_in;
   logic [SZ_W-1:0]    lb_ff, lb_in, off_ff, off_in, sum_ff, sum_in, tot_ff, tot_in;
   logic [40:0]        tlo_ff, tlo_in;
   rsp_payload_type    rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   check_type          chk;
   mul_req_type        mreq;
   logic [MUL_P_W-1:0] prod;

   logic               out_free, load, last, accept;
   logic [8:0]         iter_inc;
   logic [47:0]        lin_s;
   logic [48:0]        mic_t, byt_t;
   logic               lin_more, mic_more;

   // setup helpers
   logic [14:0]        w_sh, h_sh;
   logic [11:0]        d_sh;
   logic [15:0]        w_b, h_b, w_1, h_1, d_1;
   logic [16:0]        lin_mask, mac_wm, mac_hm;
   logic [16:0]        h_mic, h_mac;
   logic [58:0]        acc_sum;
   logic [70:0]        tot_sum;

   tmcl_check u_check (.desc(desc_ff), .chk(chk));
   tmcl_mul   u_mul   (.clock(clock), .req(mreq), .prod(prod));

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign last     = (lvl_ff == lvl_last_ff);
   assign accept   = req_chan.valid && req_chan.ready;

   // loop decisions
   always_comb begin
      iter_inc = iter_ff + 9'd1;
      lin_s    = prod[47:0] << desc_ff.samples_log2;
      mic_t    = {1'b0, prod[47:0] << desc_ff.samples_log2} + 49'd7;
      byt_t    = {1'b0, prod[47:0]} + 49'd7;
      lin_more = !iter_inc[8] && (lin_s[5:0] != 6'd0);
      mic_more = !iter_inc[8] && (mic_t[10:3] != 8'd0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_chan.valid) state_in = ST_CHECK;
         ST_CHECK:     state_in = chk.err ? ST_ERR : ST_SETUP;
         ST_ERR:       if (out_free) state_in = ST_IDLE;
         ST_SETUP:     state_in = ST_ALIGN;
         ST_ALIGN: begin
            case (desc_ff.tiling_kind)
               KIND_LINEAR: state_in = ST_LIN_MUL;
               KIND_MICRO:  state_in = ST_MIC_MUL;
               default:     state_in = ST_MAC_MUL;
            endcase
         end
         ST_LIN_MUL:   state_in = ST_LIN_CHK;
         ST_LIN_CHK:   state_in = lin_more ? ST_LIN_MUL : ST_BYTES_MUL;
         ST_MIC_MUL:   state_in = ST_MIC_MULB;
         ST_MIC_MULB:  state_in = ST_MIC_CHK;
         ST_MIC_CHK:   state_in = mic_more ? ST_MIC_MUL : ST_DEP_MUL;
         ST_MAC_MUL:   state_in = ST_BYTES_MUL;
         ST_BYTES_MUL: state_in = ST_BYTES_CHK;
         ST_BYTES_CHK: state_in = ST_DEP_MUL;
         ST_DEP_MUL:   state_in = ST_DEP_CHK;
         ST_DEP_CHK:   state_in = ST_ACC;
         ST_ACC:       state_in = last ? ST_TOT_LO : ST_EMIT;
         ST_TOT_LO:    state_in = ST_TOT_HI;
         ST_TOT_HI:    state_in = ST_TOT_SUM;
         ST_TOT_SUM:   state_in = ST_EMIT;
         ST_EMIT:      if (out_free) state_in = last ? ST_IDLE : ST_SETUP;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake, result load, multiplier operands
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      load           = out_free && ((state_ff == ST_EMIT) || (state_ff == ST_ERR));
      mreq.a         = {31'd0, p_ff};
      mreq.b         = h_ff;
      case (state_ff)
         ST_MIC_MULB: begin
            mreq.a = prod[47:0];
            mreq.b = {4'd0, b_ff};
         end
         ST_BYTES_MUL: begin
            mreq.a = (desc_ff.tiling_kind == KIND_MACRO) ? prod[47:0] : s_ff;
            mreq.b = {4'd0, b_ff};
         end
         ST_DEP_MUL: begin
            mreq.a = sz_ff;
            mreq.b = {3'd0, d_ff};
         end
         ST_TOT_LO: begin
            mreq.a = {19'd0, sum_ff[28:0]};
            mreq.b = {4'd0, desc_ff.layer_count};
         end
         ST_TOT_HI: begin
            mreq.a = {19'd0, sum_ff[57:29]};
            mreq.b = {4'd0, desc_ff.layer_count};
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      desc_in = desc_ff;  ext_in = ext_ff;  lvl_in = lvl_ff;  lvl_last_in = lvl_last_ff;
      w_in = w_ff;  h_in = h_ff;  d_in = d_ff;  b_in = b_ff;  a_in = a_ff;  p_in = p_ff;
      iter_in = iter_ff;  s_in = s_ff;  sz_in = sz_ff;  lb_in = lb_ff;  off_in = off_ff;
      sum_in = sum_ff;  tot_in = tot_ff;  tlo_in = tlo_ff;  rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      w_sh = desc_ff.pitch_elements >> lvl_ff;
      h_sh = desc_ff.height_rows >> lvl_ff;
      d_sh = desc_ff.depth_slices >> lvl_ff;
      w_b  = desc_ff.block_compressed ? (({1'b0, w_sh} + 16'd3) >> 2) : {1'b0, w_sh};
      h_b  = desc_ff.block_compressed ? (({1'b0, h_sh} + 16'd3) >> 2) : {1'b0, h_sh};
      w_1  = (w_b == 16'd0) ? 16'd1 : w_b;
      h_1  = (h_b == 16'd0) ? 16'd1 : h_b;
      d_1  = (d_sh == 12'd0) ? 16'd1 : {4'd0, d_sh};

      lin_mask = {10'd0, a_ff} - 17'd1;
      mac_wm   = {8'd0, ext_ff.ew} - 17'd1;
      mac_hm   = {8'd0, ext_ff.eh} - 17'd1;
      h_mic    = ({1'b0, h_ff} + 17'd7) & ~17'd7;
      h_mac    = ({1'b0, h_ff} + mac_hm) & ~mac_hm;
      acc_sum  = {1'b0, sum_ff} + {1'b0, lb_ff};
      tot_sum  = {prod[40:0], 29'd0} + {30'd0, tlo_ff};

      if (accept) desc_in = req_chan.payload;

      case (state_ff)
         ST_CHECK: begin
            ext_in = chk.ext;
            lvl_in = 4'd0;
            sum_in = '0;
            if (desc_ff.level_count == 5'd0)
               lvl_last_in = 4'd0;
            else if ({27'd0, desc_ff.level_count} > MAX_LEVELS)
               lvl_last_in = 4'(MAX_LEVELS - 1);
            else
               lvl_last_in = 4'(desc_ff.level_count - 5'd1);
         end
         ST_SETUP: begin
            w_in = desc_ff.pow2_pad ? pow2_up(w_1) : w_1;
            h_in = desc_ff.pow2_pad ? pow2_up(h_1) : h_1;
            d_in = 13'(desc_ff.pow2_pad ? pow2_up(d_1) : d_1);
            b_in = desc_ff.block_compressed ? {desc_ff.bits_per_element, 4'd0}
                                            : {4'd0, desc_ff.bits_per_element};
            a_in = lin_align(10'(({1'b0, b_in} + 13'd7) >> 3));
            iter_in = '0;
         end
         ST_ALIGN: begin
            case (desc_ff.tiling_kind)
               KIND_LINEAR: p_in = ({1'b0, w_ff} + lin_mask) & ~lin_mask;
               KIND_MICRO: begin
                  p_in = ({1'b0, w_ff} + 17'd7) & ~17'd7;
                  h_in = h_mic[15:0];
               end
               default: begin
                  p_in = ({1'b0, w_ff} + mac_wm) & ~mac_wm;
                  h_in = h_mac[15:0];
               end
            endcase
         end
         ST_LIN_CHK: begin
            s_in    = lin_s;
            p_in    = p_ff + {10'd0, a_ff};
            iter_in = iter_inc;
         end
         ST_MIC_CHK: begin
            sz_in   = mic_t[48:3] == 46'd0 ? 48'd0 : {2'd0, mic_t[48:3]};
            p_in    = p_ff + 17'd8;
            iter_in = iter_inc;
         end
         ST_BYTES_CHK: sz_in = {2'd0, byt_t[48:3]};
         ST_DEP_CHK:   lb_in = (prod > {{(MUL_P_W-SZ_W){1'b0}}, CAP58}) ? CAP58 : prod[SZ_W-1:0];
         ST_ACC: begin
            off_in = sum_ff;
            sum_in = acc_sum[SZ_W] ? CAP58 : acc_sum[SZ_W-1:0];
            tot_in = '0;
         end
         ST_TOT_HI:  tlo_in = prod[40:0];
         ST_TOT_SUM: tot_in = (tot_sum > {13'd0, CAP58}) ? CAP58 : tot_sum[SZ_W-1:0];
         default: ;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         if (state_ff == ST_ERR) begin
            rsp_in = '{level_index: 4'd0, level_offset: '0, level_bytes: '0,
                       total_bytes: '0, last_level: 1'b1, error: 1'b1};
         end else begin
            rsp_in = '{level_index: lvl_ff, level_offset: off_ff, level_bytes: lb_ff,
                       total_bytes: last ? tot_ff : '0, last_level: last, error: 1'b0};
            lvl_in = lvl_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;  ext_ff <= ext_in;  lvl_ff <= lvl_in;  lvl_last_ff <= lvl_last_in;
      w_ff <= w_in;  h_ff <= h_in;  d_ff <= d_in;  b_ff <= b_in;  a_ff <= a_in;  p_ff <= p_in;
      iter_ff <= iter_in;  s_ff <= s_in;  sz_ff <= sz_in;  lb_ff <= lb_in;  off_ff <= off_in;
      sum_ff <= sum_in;  tot_ff <= tot_in;  tlo_ff <= tlo_in;  rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   `TMCL_ASSERT_NXT(a_accept_to_check, accept, state_ff == ST_CHECK, "accepted beat did not start check")
   `TMCL_ASSERT_IMP(a_err_is_last, rsp_valid_ff && rsp_ff.error, rsp_ff.last_level, "error beat not last")
   `TMCL_ASSERT_NXT(a_load_shows, load, rsp_valid_ff, "loaded result beat not presented")
   `TMCL_ASSERT_IMP(a_iter_bound, iter_ff[8], iter_ff[7:0] == 8'd0, "padding loop ran past its bound")

endmodule

[rtl/tmcl_check.sv]
// Descriptor legality check and macro tile extent lookup.
module tmcl_check import tmcl_pkg::*; (
   input  req_payload_type desc,
   output check_type       chk
);

   logic [1:0] col;
   extent_type ext;
   logic       bad_macro;
   logic [7:0] bits;

   always_comb begin
      bits = desc.bits_per_element;
      if (bits[6])      col = 2'd3;
      else if (bits[5]) col = 2'd2;
      else if (bits[4]) col = 2'd1;
      else              col = 2'd0;
      ext = tile_extent(desc.tile_table_index, col);
      bad_macro = desc.is_cube || desc.block_compressed || (desc.samples_log2 != 2'd0) ||
                  (bits < 8'd8) || (bits > 8'd64) ||
                  ({27'd0, desc.tile_table_index} >= TILE_TABLE_ROWS) ||
                  (ext.ew == 9'd0) || (ext.eh == 9'd0);
      chk.ext = ext;
      chk.err = (desc.tiling_kind == KIND_RESERVED) || (bits == 8'd0) ||
                ((desc.tiling_kind == KIND_LINEAR) && desc.is_cube) ||
                ((desc.tiling_kind == KIND_MACRO) && bad_macro);
   end

endmodule

[rtl/tmcl_mul.sv]
// Shared 48x16 multiplier with registered product.
module tmcl_mul import tmcl_pkg::*; (
   input  logic               clock,
   input  mul_req_type        req,
   output logic [MUL_P_W-1:0] prod
);

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= {{MUL_B_W{1'b0}}, req.a} * {{MUL_A_W{1'b0}}, req.b};
   end

   assign prod = prod_ff;

endmodule

[sim/tb_texture_mip_chain_size_layout_core.sv]
// Testbench for the mip chain layout core: directed and random descriptors checked level by level.
module tb_texture_mip_chain_size_layout_core;
   import tmcl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 200000;
   localparam int RANDOM_DESCS    = 220;
   localparam int TAIL_CYCLES     = 300;
   localparam logic [1:0] KIND_BAD = 2'd3;

   typedef struct {
      req_payload_type desc;
      bit              drain;
   } desc_entry_type;

   logic clock;
   logic reset;

   tmcl_req_if req_chan ();
   tmcl_rsp_if rsp_chan ();

   texture_mip_chain_size_layout_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   desc_entry_type  desc_q[$];
   rsp_payload_type level_q[$];
   int              mismatches = 0;
   int              desc_taken = 0;
   int              calm_left  = 0;
   int              req_gap    = 0;
   int              rsp_hold   = 0;
   bit              long_hold_done = 0;
   int              idle_cycles = 0;

   // macro tile extents: A 256x128, B 256x256, C 128x128, D 128x64, E 64x64, Z none
   string extent_rows[32] = '{
      "AAAA", "ACCC", "ACDD", "ACDD", "ACDD", "ZZZZ", "BACC", "BACD",
      "ZZZZ", "ZZZZ", "ACDD", "BACD", "BACD", "ZZZZ", "ACDD", "ACDD",
      "BACD", "BACD", "BACD", "ZZZZ", "DDEE", "DDEE", "CDEE", "CDEE",
      "CDEE", "DEEE", "DEEE", "ZZZZ", "ZZZZ", "ZZZZ", "ZZZZ", "ZZZZ"};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [63:0] cap_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > CAP58) ? 64'(CAP58) : s;
   endfunction

   function automatic logic [63:0] cap_mul(logic [63:0] a, logic [63:0] b);
      if (a == 0 || b == 0) return 64'd0;
      if (a > 64'(CAP58) / b) return 64'(CAP58);
      return a * b;
   endfunction

   function automatic logic [31:0] round_pow2(logic [31:0] v);
      logic [31:0] p;
      p = 1;
      while (p < v && p < 32'h8000_0000) p = p << 1;
      return p;
   endfunction

   function automatic logic [63:0] linear_bytes(logic [31:0] w, logic [31:0] h,
                                                logic [31:0] b, logic [31:0] n);
      logic [31:0] ebytes, al, pm;
      logic [63:0] p, s;
      int i;
      ebytes = (b + 7) / 8;
      al = 64 / ebytes;
      if (al < 8) al = 8;
      pm = (w + al - 1) & ~(al - 1);
      p = 64'(pm);
      s = 1;
      for (i = 0; i < 256 && (s % 64) != 0; i++) begin
         s = p * h * n;
         p = p + al;
      end
      return (s * b + 7) / 8;
   endfunction

   function automatic logic [63:0] micro_bytes(logic [31:0] w, logic [31:0] h,
                                               logic [31:0] b, logic [31:0] n);
      logic [63:0] p, ha, s;
      int i;
      p = 64'((w + 7) & ~32'd7);
      ha = 64'((h + 7) & ~32'd7);
      s = 1;
      for (i = 0; i < 256 && (s % 256) != 0; i++) begin
         s = (p * ha * b * n + 7) / 8;
         p = p + 8;
      end
      return s;
   endfunction

   function automatic int extent_of(byte c, bit want_h);
      case (c)
         "A": return want_h ? 128 : 256;
         "B": return 256;
         "C": return 128;
         "D": return want_h ? 64 : 128;
         "E": return 64;
         default: return 0;
      endcase
   endfunction

   // expected level beats of one descriptor
   function automatic void predict_mip_chain(req_payload_type d);
      rsp_payload_type r;
      logic [31:0] w, h, dp, b, n, ew, eh, lvls, lg, pa, hm;
      logic [63:0] sz, sum;
      bit bad;
      int col;
      n = 32'd1 << d.samples_log2;
      lvls = 32'(d.level_count);
      if (lvls == 0) lvls = 1;
      if (lvls > MAX_LEVELS) lvls = MAX_LEVELS;
      bad = (d.tiling_kind == KIND_BAD) || (d.bits_per_element == 0);
      if (d.tiling_kind == KIND_LINEAR && d.is_cube) bad = 1;
      ew = 0;
      eh = 0;
      if (d.tiling_kind == KIND_MACRO) begin
         if (d.is_cube || d.block_compressed || d.samples_log2 != 0 ||
             d.bits_per_element < 8 || d.bits_per_element > 64 ||
             d.tile_table_index >= TILE_TABLE_ROWS) begin
            bad = 1;
         end else begin
            lg = 0;
            b = 32'(d.bits_per_element);
            while (b > 1) begin b = b >> 1; lg++; end
            col = (lg - 3) & 3;
            ew = extent_of(extent_rows[d.tile_table_index][col], 0);
            eh = extent_of(extent_rows[d.tile_table_index][col], 1);
            if (ew == 0 || eh == 0) bad = 1;
         end
      end
      if (bad) begin
         r = '0;
         r.last_level = 1'b1;
         r.error = 1'b1;
         level_q.push_back(r);
         return;
      end
      sum = 0;
      for (int m = 0; m < lvls; m++) begin
         b = 32'(d.bits_per_element);
         w = 32'(d.pitch_elements) >> m;
         h = 32'(d.height_rows) >> m;
         dp = 32'(d.depth_slices) >> m;
         if (d.block_compressed) begin
            w = (w + 3) / 4;
            h = (h + 3) / 4;
            b = b * 16;
         end
         if (w < 1) w = 1;
         if (h < 1) h = 1;
         if (dp < 1) dp = 1;
         if (d.pow2_pad) begin
            w = round_pow2(w);
            h = round_pow2(h);
            dp = round_pow2(dp);
         end
         if (d.tiling_kind == KIND_LINEAR) sz = linear_bytes(w, h, b, n);
         else if (d.tiling_kind == KIND_MICRO) sz = micro_bytes(w, h, b, n);
         else begin
            pa = (w + ew - 1) & ~(ew - 1);
            hm = (h + eh - 1) & ~(eh - 1);
            sz = (64'(pa) * 64'(hm) * b + 7) / 8;
         end
         sz = cap_mul(sz, 64'(dp));
         r = '0;
         r.level_index = 4'(m);
         r.level_offset = sum[SZ_W-1:0];
         r.level_bytes = sz[SZ_W-1:0];
         sum = cap_add(sum, sz);
         if (m == lvls - 1) begin
            sz = cap_mul(sum, 64'(d.layer_count));
            r.total_bytes = sz[SZ_W-1:0];
            r.last_level = 1'b1;
         end
         level_q.push_back(r);
      end
   endfunction

   function automatic req_payload_type make_desc(int pitch, int height, int depth, int bits,
         bit block, bit pad, logic [1:0] kind, int row, int levels, int layers,
         int slog, bit cube);
      req_payload_type d;
      d.pitch_elements = 15'(pitch);
      d.height_rows = 15'(height);
      d.depth_slices = 12'(depth);
      d.bits_per_element = 8'(bits);
      d.block_compressed = block;
      d.pow2_pad = pad;
      d.tiling_kind = kind;
      d.tile_table_index = 5'(row);
      d.level_count = 5'(levels);
      d.layer_count = 12'(layers);
      d.samples_log2 = 2'(slog);
      d.is_cube = cube;
      return d;
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 300);
      if (r < 90) return $urandom_range(1, 16384);
      return $urandom_range(0, 32767);
   endfunction

   function automatic req_payload_type random_desc();
      req_payload_type d;
      int r;
      d = make_desc(pick_dim(), pick_dim(),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(1, 4),
                    $urandom_range(1, 128), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)),
                    KIND_LINEAR, $urandom_range(0, 31), $urandom_range(1, 16),
                    $urandom_range(1, 64), $urandom_range(0, 3), 1'b0);
      r = $urandom_range(0, 99);
      if (r < 30) begin
         d.tiling_kind = KIND_LINEAR;
      end else if (r < 60) begin
         d.tiling_kind = KIND_MICRO;
         d.is_cube = 1'($urandom_range(0, 1));
      end else if (r < 90) begin
         // macro descriptor, well formed but for rows with no tile extent
         d.tiling_kind = KIND_MACRO;
         d.block_compressed = 0;
         d.samples_log2 = 0;
         d.tile_table_index = 5'($urandom_range(0, TILE_TABLE_ROWS - 1));
         d.bits_per_element = 8'(($urandom_range(0, 1)) ? (8 << $urandom_range(0, 3))
                                                        : $urandom_range(8, 64));
      end else begin
         // noise: any field value at all
         d = req_payload_type'(($bits(req_payload_type))'({$urandom, $urandom, $urandom}));
      end
      if ($urandom_range(0, 9) == 0) d.layer_count = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 9) == 0) d.level_count = 5'($urandom_range(0, 31));
      return d;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) calm_left = $urandom_range(20, 40);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // stimulus
   initial begin
      desc_entry_type e;
      e.drain = 0;
      e.desc = make_desc(1, 1, 1, 1, 0, 0, KIND_LINEAR, 0, 1, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(32767, 32767, 4095, 255, 0, 0, KIND_LINEAR, 0, 16, 4095, 3, 0);
      desc_q.push_back(e);
      e.desc = make_desc(16384, 16384, 2048, 128, 1, 1, KIND_MICRO, 0, 31, 2048, 3, 1);
      desc_q.push_back(e);
      e.desc = make_desc(100, 60, 5, 24, 0, 0, KIND_LINEAR, 0, 0, 3, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(77, 33, 1, 40, 0, 0, KIND_LINEAR, 0, 4, 0, 1, 0); desc_q.push_back(e);
      e.desc = make_desc(77, 33, 1, 56, 0, 1, KIND_LINEAR, 0, 5, 2, 2, 0); desc_q.push_back(e);
      e.desc = make_desc(9, 9, 3, 8, 0, 0, KIND_MICRO, 0, 5, 1, 0, 1); desc_q.push_back(e);
      e.desc = make_desc(300, 200, 1, 8, 0, 0, KIND_MACRO, 0, 9, 6, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(300, 200, 1, 64, 0, 1, KIND_MACRO, 26, 9, 6, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(500, 90, 2, 16, 0, 0, KIND_MACRO, 7, 6, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(500, 90, 2, 32, 0, 0, KIND_MACRO, 20, 6, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 8, 0, 0, KIND_BAD, 0, 3, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 0, 0, 0, KIND_MICRO, 0, 3, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 32, 0, 0, KIND_LINEAR, 0, 3, 1, 0, 1); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 32, 0, 0, KIND_MACRO, 1, 3, 1, 0, 1); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 32, 1, 0, KIND_MACRO, 1, 3, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 32, 0, 0, KIND_MACRO, 1, 3, 1, 1, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 7, 0, 0, KIND_MACRO, 1, 3, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 65, 0, 0, KIND_MACRO, 1, 3, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 32, 0, 0, KIND_MACRO, 27, 3, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(64, 64, 1, 32, 0, 0, KIND_MACRO, 5, 3, 1, 0, 0); desc_q.push_back(e);
      e.desc = make_desc(0, 0, 0, 128, 1, 1, KIND_MICRO, 31, 16, 1, 3, 0); desc_q.push_back(e);
      for (int i = 0; i < RANDOM_DESCS; i++) begin
         e.desc = random_desc();
         e.drain = (i == 0 || i == RANDOM_DESCS / 2);
         desc_q.push_back(e);
      end

      @(negedge reset);
      while (desc_q.size() != 0 || req_chan.valid) @(posedge clock);
      while (level_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && level_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // descriptor driver; expectations are queued as each beat is taken
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.payload <= '0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_mip_chain(req_chan.payload);
            desc_taken++;
            req_gap = pick_gap();
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (desc_q.size() != 0 && !(desc_q[0].drain && level_q.size() != 0)) begin
               req_chan.valid <= 1'b1;
               req_chan.payload <= desc_q[0].desc;
               void'(desc_q.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // level sink: random stalls plus one long hold to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (!long_hold_done && desc_taken == 40) begin
         long_hold_done <= 1'b1;
         rsp_hold = 600;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_hold = pick_gap();
         rsp_chan.ready <= (rsp_hold == 0);
      end
   end

   // level checker
   always @(posedge clock) begin
      rsp_payload_type want, got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (level_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected level beat: index %0d", got.level_index);
         end else begin
            want = level_q.pop_front();
            if (got.level_index !== want.level_index || got.level_offset !== want.level_offset ||
                got.level_bytes !== want.level_bytes || got.total_bytes !== want.total_bytes ||
                got.last_level !== want.last_level || got.error !== want.error) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("level mismatch: exp idx %0d off %0d bytes %0d total %0d last %0b err %0b",
                           want.level_index, want.level_offset, want.level_bytes,
                           want.total_bytes, want.last_level, want.error);
                  $display("                got idx %0d off %0d bytes %0d total %0d last %0b err %0b",
                           got.level_index, got.level_offset, got.level_bytes,
                           got.total_bytes, got.last_level, got.error);
               end
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
